[rtl/edb_pkg.sv]
// Package for the error-diffusion binarizer: field widths, register map,
// reset values and the 12-bit saturating and share arithmetic.
// No dependencies.
package edb_pkg;

  // Field and register widths
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned IW_W    = 12;
  localparam int unsigned IH_W    = 13;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned GEO_W   = 14;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  // Geometry limits
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_HEIGHT    = 4096;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  // Register reset values
  localparam logic [IW_W-1:0]  WIDTH_RST  = IW_W'(2048);
  localparam logic [IH_W-1:0]  HEIGHT_RST = IH_W'(4096);
  localparam logic [THR_W-1:0] THRESH_RST = THR_W'(128);

  // Diffusion weights, in sixteenths
  localparam logic [2:0] K_RIGHT = 3'd7;
  localparam logic [2:0] K_DLEFT = 3'd3;
  localparam logic [2:0] K_DOWN  = 3'd5;
  localparam logic [2:0] K_DRGHT = 3'd1;

  localparam logic signed [ERR_W-1:0] ERR_MAX = ERR_W'(2047);
  localparam logic signed [ERR_W-1:0] ERR_MIN = ERR_W'(-2048);

  // Clamp a widened sum to the 12-bit signed error range
  function automatic logic signed [ERR_W-1:0] sat12(input logic signed [ERR_W+1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > (ERR_W+2)'(ERR_MAX)) begin
      r = ERR_MAX;
    end else if (v < (ERR_W+2)'(ERR_MIN)) begin
      r = ERR_MIN;
    end else begin
      r = ERR_W'(v);
    end
    return r;
  endfunction

  // e * k / 16, truncated toward zero
  function automatic logic signed [ERR_W-1:0] share(input logic signed [ERR_W-1:0] e,
                                                    input logic [2:0] k);
    logic signed [ERR_W+3:0] prod;
    logic signed [ERR_W+3:0] adj;
    prod = (ERR_W+4)'(e) * $signed({1'b0, k});
    adj  = (prod < 0) ? prod + (ERR_W+4)'(15) : prod;
    return ERR_W'(adj >>> 4);
  endfunction

endpackage

[rtl/error_diffusion_binarizer.sv]
// Error-diffusion binarizer top level: APB register file, raster counters,
// two-bank error line store and the per-pixel diffusion stage.
// Depends on edb_pkg.
//
// Usage: gray pixels enter on the input channel (in_valid_i / in_stall_o,
// gray_in_i) in raster order. For each pixel one result leaves on the output
// channel (out_valid_o / out_stall_i) with pixel_white_o, and line_end_o and
// frame_end_o marking the last pixel of a line and of the frame, taken from
// internal column and row counters. Geometry and threshold are set through
// the APB port (width at 0x0, height at 0x4, threshold at 0x8); the user must
// set them only while idle; the block does not check this. One pixel per clock
// is sustained unless the output stalls, set by the carry loop of the
// diffusion stage (error in, threshold, 7/16 share out) closing within it.
// The line store is split into even and odd column banks so a line end can
// write two columns at once; a written-column mark reset at each frame
// start makes unwritten columns read as zero, so no clearing pass is needed.
// Reset: counters at frame start, carries zero, registers at their defaults.
// A stalled receiver holds the output register; one more pixel is taken into
// the diffusion stage, after which in_stall_o rises until the output moves.
module error_diffusion_binarizer #(
  parameter int unsigned MAX_WIDTH = edb_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [edb_pkg::GRAY_W-1:0]  gray_in_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        pixel_white_o,
  output logic                        line_end_o,
  output logic                        frame_end_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [edb_pkg::ADDR_W-1:0]  paddr,
  input  logic [edb_pkg::DATA_W-1:0]  pwdata,
  output logic [edb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import edb_pkg::*;

  localparam int unsigned CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned HW_W       = CW + 1;
  localparam int unsigned BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [CW-1:0]     col;
    logic              line_last;
    logic              last_row;
    logic              frame_start;
    logic              rd_valid;
  } stage_t;

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  logic [IW_W-1:0]  width_q;
  logic [IH_W-1:0]  height_q;
  logic [THR_W-1:0] thresh_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  // Write the addressed register; ignore addresses past the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[IW_W-1:0];
        REG_HEIGHT: height_q <= pwdata[IH_W-1:0];
        REG_THRESH: thresh_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      REG_THRESH: prdata = DATA_W'(thresh_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input side: raster counters and line store read
  // ---------------------------------------------------------------------
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [GEO_W-1:0] w_eff;
  logic [IH_W-1:0]  h_eff;
  logic             s0_line_last, s0_last_row, s0_fs;
  logic             in_fire;
  logic             s1_go;

  stage_t           s1_q;
  logic             s1_valid_q;

  logic [HW_W-1:0]  hw_q, hw_d;

  logic [1:0]                   wr_en;
  logic [1:0][BA_W-1:0]         wr_addr;
  logic signed [1:0][ERR_W-1:0] wr_data;

  logic [BA_W-1:0]          rd_addr;
  logic                     fwd_hit_d, fwd_hit_q;
  logic signed [ERR_W-1:0]  fwd_data_q;
  logic signed [ERR_W-1:0]  rd_even_q, rd_odd_q;
  logic signed [ERR_W-1:0]  mem_even [BANK_DEPTH];
  logic signed [ERR_W-1:0]  mem_odd  [BANK_DEPTH];

  // Clamp geometry to its usable range
  always_comb begin
    if (width_q == '0) begin
      w_eff = GEO_W'(1);
    end else if (GEO_W'(width_q) > GEO_W'(MAX_WIDTH)) begin
      w_eff = GEO_W'(MAX_WIDTH);
    end else begin
      w_eff = GEO_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = IH_W'(1);
    end else if (height_q > IH_W'(MAX_HEIGHT)) begin
      h_eff = IH_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign s0_line_last = (GEO_W'(col_q) + GEO_W'(1)) >= w_eff;
  assign s0_last_row  = (IH_W'(row_q) + IH_W'(1)) >= h_eff;
  assign s0_fs        = (col_q == '0) && (row_q == '0);

  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // Advance position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (s0_line_last) begin
        col_d = '0;
        row_d = s0_last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Forward a write landing on the entry read in the same cycle
  assign rd_addr   = BA_W'(col_q >> 1);
  assign fwd_hit_d = wr_en[col_q[0]] && (wr_addr[col_q[0]] == rd_addr);

  // Load the diffusion stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.gray        <= gray_in_i;
      s1_q.col         <= col_q;
      s1_q.line_last   <= s0_line_last;
      s1_q.last_row    <= s0_last_row;
      s1_q.frame_start <= s0_fs;
      s1_q.rd_valid    <= !s0_fs && (HW_W'(col_q) < hw_d);
      fwd_hit_q        <= fwd_hit_d;
      fwd_data_q       <= wr_data[col_q[0]];
    end
  end

  // Even column bank
  always_ff @(posedge clk_i) begin
    if (wr_en[0]) begin
      mem_even[wr_addr[0]] <= wr_data[0];
    end
    if (in_fire) begin
      rd_even_q <= mem_even[rd_addr];
    end
  end

  // Odd column bank
  always_ff @(posedge clk_i) begin
    if (wr_en[1]) begin
      mem_odd[wr_addr[1]] <= wr_data[1];
    end
    if (in_fire) begin
      rd_odd_q <= mem_odd[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Diffusion stage
  // ---------------------------------------------------------------------
  logic signed [ERR_W-1:0] rc_q, rc_d;
  logic signed [ERR_W-1:0] pdl_q, pdl_d;
  logic signed [ERR_W-1:0] pd_q, pd_d;
  logic signed [ERR_W-1:0] mem_val, mem_use, rc_use, pdl_use, pd_use;
  logic signed [ERR_W-1:0] incoming, pix_sum, err;
  logic signed [ERR_W-1:0] sh7, sh3, sh5, sh1, dl_val, below;
  logic                    white;
  logic                    a_en, b_en;
  logic [CW-1:0]           col_m1;
  logic [BA_W-1:0]         a_addr, b_addr;
  logic signed [ERR_W-1:0] b_val;
  logic [HW_W-1:0]         hw_base, hw_top;

  logic out_valid_q, out_white_q, out_le_q, out_fe_q;

  assign s1_go = s1_valid_q && (!out_valid_q || !out_stall_i);

  // Threshold the pixel and split its error
  always_comb begin
    mem_val  = fwd_hit_q ? fwd_data_q : (s1_q.col[0] ? rd_odd_q : rd_even_q);
    mem_use  = s1_q.rd_valid ? mem_val : '0;
    rc_use   = s1_q.frame_start ? '0 : rc_q;
    pdl_use  = s1_q.frame_start ? '0 : pdl_q;
    pd_use   = s1_q.frame_start ? '0 : pd_q;
    incoming = sat12((ERR_W+2)'(rc_use) + (ERR_W+2)'(mem_use));
    pix_sum  = sat12((ERR_W+2)'(incoming) +
                     $signed({{(ERR_W+2-GRAY_W){1'b0}}, s1_q.gray}));
    white    = pix_sum >= $signed({{(ERR_W-THR_W){1'b0}}, thresh_q});
    err      = white ? pix_sum - ERR_W'(255) : pix_sum;
    sh7      = share(err, K_RIGHT);
    sh3      = share(err, K_DLEFT);
    sh5      = share(err, K_DOWN);
    sh1      = share(err, K_DRGHT);
    dl_val   = sat12((ERR_W+2)'(pdl_use) + (ERR_W+2)'(sh3));
    below    = sat12((ERR_W+2)'(pd_use) + (ERR_W+2)'(sh5));
  end

  // Line store writes: down-left column, and own column at line end or last row
  always_comb begin
    col_m1 = s1_q.col - CW'(1);
    a_en   = !s1_q.last_row && (s1_q.col != '0);
    b_en   = s1_q.last_row || s1_q.line_last;
    a_addr = BA_W'(col_m1 >> 1);
    b_addr = BA_W'(s1_q.col >> 1);
    b_val  = s1_q.last_row ? '0 : below;
    if (s1_q.col[0]) begin
      wr_en[1]   = s1_go && b_en;
      wr_addr[1] = b_addr;
      wr_data[1] = b_val;
      wr_en[0]   = s1_go && a_en;
      wr_addr[0] = a_addr;
      wr_data[0] = dl_val;
    end else begin
      wr_en[0]   = s1_go && b_en;
      wr_addr[0] = b_addr;
      wr_data[0] = b_val;
      wr_en[1]   = s1_go && a_en;
      wr_addr[1] = a_addr;
      wr_data[1] = dl_val;
    end
  end

  // Next carries and written-column mark
  always_comb begin
    rc_d    = rc_q;
    pdl_d   = pdl_q;
    pd_d    = pd_q;
    hw_d    = hw_q;
    hw_base = s1_q.frame_start ? '0 : hw_q;
    if (b_en) begin
      hw_top = HW_W'(s1_q.col) + HW_W'(1);
    end else if (a_en) begin
      hw_top = HW_W'(s1_q.col);
    end else begin
      hw_top = '0;
    end
    if (s1_go) begin
      rc_d = s1_q.line_last ? '0 : sh7;
      if (s1_q.last_row || s1_q.line_last) begin
        pdl_d = '0;
        pd_d  = '0;
      end else begin
        pdl_d = below;
        pd_d  = sh1;
      end
      hw_d = (hw_top > hw_base) ? hw_top : hw_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      pdl_q <= '0;
      pd_q  <= '0;
      hw_q  <= '0;
    end else begin
      rc_q  <= rc_d;
      pdl_q <= pdl_d;
      pd_q  <= pd_d;
      hw_q  <= hw_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: load on advance, drop after a transfer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_white_q <= white;
      out_le_q    <= s1_q.line_last;
      out_fe_q    <= s1_q.line_last & s1_q.last_row;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_white_o = out_white_q;
  assign line_end_o    = out_le_q;
  assign frame_end_o   = out_fe_q;

endmodule
